FILE: rtl/rztb_pkg.sv
// Shared types and constants for the reverb zone top-two blend unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rztb_pkg;

  localparam int MAX_ZONES = 64;
  localparam int ZCW       = $clog2(MAX_ZONES + 1);
  localparam int NPARAM    = 7;
  localparam int NLANE     = NPARAM + 1;
  localparam int LANE_W    = $clog2(NLANE);
  localparam int DIV_W     = 25;
  localparam int QUO_W     = 16;
  localparam int QCNT_W    = $clog2(QUO_W);
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [6:0]  NO_SLOT  = 7'h7F;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_WDIV, ST_UPDATE, ST_DECIDE,
    ST_TDIV, ST_MIX, ST_SCALE, ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic w_load_div;
    logic update;
    logic decide;
    logic t_load_div;
    logic mix;
    logic scale;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic last;
    logic second_vld;
    logic mix_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/rztb_div.sv
// Restoring divider, one quotient bit per cycle, remainder below divisor.
// Depends on rztb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module rztb_div import rztb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic [DIV_W:0]    rem2;
  logic              qbit;

  // Shift and trial subtract
  always_comb begin
    rem2 = {rem, 1'b0};
    qbit = (rem2 >= {1'b0, dvs});
  end

  // Advance one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= qbit ? DIV_W'(rem2 - {1'b0, dvs}) : rem2[DIV_W-1:0];
      quo <= {quo[QUO_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rztb_ctrl.sv
// Sequencer for zone evaluation, tracking update and result blending.
// Depends on rztb_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module rztb_ctrl import rztb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_EVAL;
      ST_EVAL:   state_next = sts.need_div ? ST_WDIV : ST_UPDATE;
      ST_WDIV:   if (sts.div_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = sts.last ? ST_DECIDE : ST_IDLE;
      ST_DECIDE: state_next = sts.second_vld ? ST_TDIV : ST_MIX;
      ST_TDIV:   if (sts.div_done) state_next = ST_MIX;
      ST_MIX:    if (sts.mix_done) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_FINISH;
      ST_FINISH: if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL:   cmd.eval = 1'b1;
      ST_WDIV:   cmd.w_load_div = sts.div_done;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_TDIV:   cmd.t_load_div = sts.div_done;
      ST_MIX:    cmd.mix = 1'b1;
      ST_SCALE:  cmd.scale = 1'b1;
      ST_FINISH: cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/rztb_datapath.sv
// Zone weight, top-two tracking, blend lanes and output register.
// Depends on rztb_pkg and rztb_div.
`timescale 1ns / 1ps
`default_nettype none
module rztb_datapath import rztb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic signed [23:0] core_radius,
  input  wire logic signed [23:0] falloff_band,
  input  wire logic signed [23:0] distance,
  input  wire logic [15:0]        decay_code,
  input  wire logic [15:0]        density_code,
  input  wire logic [15:0]        diffusion_code,
  input  wire logic [15:0]        gain_code,
  input  wire logic [15:0]        gain_hf_code,
  input  wire logic [15:0]        early_delay_code,
  input  wire logic [15:0]        late_delay_code,
  input  wire logic [16:0]        wet_gain,
  input  wire logic               last_zone,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [6:0]       winner_index,
  output logic signed [6:0]       neighbour_index,
  output logic [15:0]             blend_factor,
  output logic [16:0]             winner_weight,
  output logic [15:0]             out_decay,
  output logic [15:0]             out_density,
  output logic [15:0]             out_diffusion,
  output logic [15:0]             out_gain,
  output logic [15:0]             out_gain_hf,
  output logic [15:0]             out_early_delay,
  output logic [15:0]             out_late_delay,
  output logic [16:0]             target_wet
);

  // Captured transaction
  logic [22:0] r, b, d;
  logic [15:0] p [NPARAM];
  logic [16:0] wet;
  logic        last;

  // Tracking
  logic [ZCW-1:0] zone_count;
  logic [16:0]    best_weight, second_weight;
  logic [6:0]     best_slot, second_slot;
  logic           best_vld, second_vld;
  logic [15:0]    best_params [NPARAM];
  logic [15:0]    second_params [NPARAM];
  logic [16:0]    best_wet, second_wet;

  // Work registers
  logic [16:0]       w;
  logic [15:0]       t;
  logic [LANE_W-1:0] lane;
  logic [16:0]       mix_res [NLANE];
  logic [16:0]       scaled;

  // Divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_num, div_den;
  logic [QUO_W-1:0] div_quo;

  logic [23:0] sum_rb;
  logic        full_w, zero_w;
  logic [16:0] mix_a, mix_b, one_minus_t;
  logic [34:0] mix_sum;
  logic [33:0] scale_prod;

  // Weight classification
  always_comb begin
    sum_rb = {1'b0, r} + {1'b0, b};
    full_w = (d <= r);
    zero_w = (b == '0) || ({1'b0, d} >= sum_rb);
  end

  // Divider operand selection
  always_comb begin
    div_start = (cmd.eval && !full_w && !zero_w) || (cmd.decide && second_vld);
    if (cmd.decide) begin
      div_num = DIV_W'(second_weight);
      div_den = DIV_W'({1'b0, best_weight} + {1'b0, second_weight});
    end else begin
      div_num = DIV_W'(sum_rb - {1'b0, d});
      div_den = DIV_W'(b);
    end
  end

  rztb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Blend lane: (a*(1-t) + b*t) >> 16
  always_comb begin
    if (lane == LANE_W'(NPARAM)) begin
      mix_a = best_wet;
      mix_b = second_wet;
    end else begin
      mix_a = {1'b0, best_params[lane[LANE_W-1:0]]};
      mix_b = {1'b0, second_params[lane[LANE_W-1:0]]};
    end
    one_minus_t = ONE_Q16 - {1'b0, t};
    mix_sum     = 35'(mix_a * one_minus_t) + 35'(mix_b * {1'b0, t});
    scale_prod  = mix_res[NLANE-1] * best_weight;
  end

  // Status
  always_comb begin
    sts.need_div   = !full_w && !zero_w;
    sts.div_done   = div_done;
    sts.last       = last;
    sts.second_vld = second_vld;
    sts.mix_done   = (lane == LANE_W'(NLANE - 1));
    sts.out_free   = !out_valid || out_ready;
  end

  // Capture transaction, clamp negatives, saturate wet gain
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r    <= core_radius[23]  ? '0 : core_radius[22:0];
      b    <= falloff_band[23] ? '0 : falloff_band[22:0];
      d    <= distance[23]     ? '0 : distance[22:0];
      p[0] <= decay_code;
      p[1] <= density_code;
      p[2] <= diffusion_code;
      p[3] <= gain_code;
      p[4] <= gain_hf_code;
      p[5] <= early_delay_code;
      p[6] <= late_delay_code;
      wet  <= (wet_gain > ONE_Q16) ? ONE_Q16 : wet_gain;
      last <= last_zone;
    end
    if (cmd.eval) w <= full_w ? ONE_Q16 : '0;
    else if (cmd.w_load_div) w <= {1'b0, div_quo};
    if (cmd.decide) t <= '0;
    else if (cmd.t_load_div) t <= div_quo;
    if (cmd.mix) mix_res[lane] <= mix_sum[32:16];
    if (cmd.scale) scaled <= scale_prod[32:16];
  end

  // Lane counter
  always_ff @(posedge clk) begin
    if (rst) lane <= '0;
    else if (cmd.decide) lane <= '0;
    else if (cmd.mix && lane != LANE_W'(NLANE - 1)) lane <= lane + 1'b1;
  end

  // Top-two tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count    <= '0;
      best_weight   <= '0;
      second_weight <= '0;
      best_vld      <= 1'b0;
      second_vld    <= 1'b0;
    end else if (cmd.load_out) begin
      zone_count    <= '0;
      best_weight   <= '0;
      second_weight <= '0;
      best_vld      <= 1'b0;
      second_vld    <= 1'b0;
    end else if (cmd.update && zone_count < ZCW'(MAX_ZONES)) begin
      zone_count <= zone_count + 1'b1;
      if (w != '0 && w > best_weight) begin
        second_weight <= best_weight;
        second_vld    <= best_vld;
        best_weight   <= w;
        best_vld      <= 1'b1;
      end else if (w != '0 && w > second_weight) begin
        second_weight <= w;
        second_vld    <= 1'b1;
      end
    end
  end

  // Stored zone payload
  always_ff @(posedge clk) begin
    if (cmd.update && zone_count < ZCW'(MAX_ZONES) && w != '0) begin
      if (w > best_weight) begin
        second_slot   <= best_slot;
        second_params <= best_params;
        second_wet    <= best_wet;
        best_slot     <= 7'(zone_count);
        best_params   <= p;
        best_wet      <= wet;
      end else if (w > second_weight) begin
        second_slot   <= 7'(zone_count);
        second_params <= p;
        second_wet    <= wet;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (best_vld) begin
        winner_index    <= best_slot;
        neighbour_index <= second_vld ? second_slot : NO_SLOT;
        blend_factor    <= t;
        winner_weight   <= best_weight;
        out_decay       <= mix_res[0][15:0];
        out_density     <= mix_res[1][15:0];
        out_diffusion   <= mix_res[2][15:0];
        out_gain        <= mix_res[3][15:0];
        out_gain_hf     <= mix_res[4][15:0];
        out_early_delay <= mix_res[5][15:0];
        out_late_delay  <= mix_res[6][15:0];
        target_wet      <= scaled;
      end else begin
        winner_index    <= NO_SLOT;
        neighbour_index <= NO_SLOT;
        blend_factor    <= '0;
        winner_weight   <= '0;
        out_decay       <= '0;
        out_density     <= '0;
        out_diffusion   <= '0;
        out_gain        <= '0;
        out_gain_hf     <= '0;
        out_early_delay <= '0;
        out_late_delay  <= '0;
        target_wet      <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/reverb_zone_top_two_blend_unit.sv
// Top level of the reverb zone top-two blend unit.
// Depends on rztb_pkg, rztb_ctrl, rztb_datapath (which holds rztb_div).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | zone geometry, 7 codes, wet, last
//   out     | output    | out_valid / out_ready| indices, t, weight, blend, wet
//
// A zone with full or zero weight passes capture, evaluation and update; any
// other zone also waits on the 16-step divider for its falloff. A last zone
// then adds the decide state, the divider for t when a neighbour exists, all
// eight lanes in turn through the single blend lane, scaling and the output load.
// Reset is synchronous and clears tracking and the output valid. A stalled
// output holds its result; the next zone is accepted meanwhile and only a
// second result waits.
`timescale 1ns / 1ps
`default_nettype none
module reverb_zone_top_two_blend_unit import rztb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] core_radius,
  input  wire logic signed [23:0] falloff_band,
  input  wire logic signed [23:0] distance,
  input  wire logic [15:0]        decay_code,
  input  wire logic [15:0]        density_code,
  input  wire logic [15:0]        diffusion_code,
  input  wire logic [15:0]        gain_code,
  input  wire logic [15:0]        gain_hf_code,
  input  wire logic [15:0]        early_delay_code,
  input  wire logic [15:0]        late_delay_code,
  input  wire logic [16:0]        wet_gain,
  input  wire logic               last_zone,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [6:0]       winner_index,
  output logic signed [6:0]       neighbour_index,
  output logic [15:0]             blend_factor,
  output logic [16:0]             winner_weight,
  output logic [15:0]             out_decay,
  output logic [15:0]             out_density,
  output logic [15:0]             out_diffusion,
  output logic [15:0]             out_gain,
  output logic [15:0]             out_gain_hf,
  output logic [15:0]             out_early_delay,
  output logic [15:0]             out_late_delay,
  output logic [16:0]             target_wet
);

  cmd_t cmd;
  sts_t sts;

  rztb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rztb_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .core_radius      (core_radius),
    .falloff_band     (falloff_band),
    .distance         (distance),
    .decay_code       (decay_code),
    .density_code     (density_code),
    .diffusion_code   (diffusion_code),
    .gain_code        (gain_code),
    .gain_hf_code     (gain_hf_code),
    .early_delay_code (early_delay_code),
    .late_delay_code  (late_delay_code),
    .wet_gain         (wet_gain),
    .last_zone        (last_zone),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .winner_index     (winner_index),
    .neighbour_index  (neighbour_index),
    .blend_factor     (blend_factor),
    .winner_weight    (winner_weight),
    .out_decay        (out_decay),
    .out_density      (out_density),
    .out_diffusion    (out_diffusion),
    .out_gain         (out_gain),
    .out_gain_hf      (out_gain_hf),
    .out_early_delay  (out_early_delay),
    .out_late_delay   (out_late_delay),
    .target_wet       (target_wet)
  );

  // One zone in flight at a time
  a_one_zone: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("zone accepted while previous zone still in flight");

  // No winner implies no neighbour
  a_no_neighbour: assert property (@(posedge clk) disable iff (rst)
    out_valid && winner_index == NO_SLOT |-> neighbour_index == NO_SLOT)
    else $error("neighbour reported without winner");

  // Empty result carries zero weight and wet
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && winner_index == NO_SLOT |-> winner_weight == '0 && target_wet == '0)
    else $error("empty result carries nonzero weight");

  // Neighbour share never exceeds one half
  a_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> blend_factor <= 16'h8000)
    else $error("blend factor above one half");

endmodule
`default_nettype wire

FILE: tb/sv/tb_reverb_zone_top_two_blend_unit.sv
// Testbench for the reverb zone top-two blend unit: directed table plus random zone sets.
// Depends on rztb_pkg and reverb_zone_top_two_blend_unit; a local model predicts each result.
`timescale 1ns / 1ps
module tb_reverb_zone_top_two_blend_unit;
  import rztb_pkg::*;

  typedef struct {
    logic signed [23:0] r, b, d;
    logic [15:0] p [NPARAM];
    logic [16:0] wet;
    logic last;
  } zone_t;

  typedef struct {
    logic [6:0] wi, ni;
    logic [15:0] t;
    logic [16:0] ww;
    logic [15:0] p [NPARAM];
    logic [16:0] tw;
  } blend_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, in_ready, out_valid;
  logic signed [23:0] core_radius = 0, falloff_band = 0, distance = 0;
  logic [15:0] decay_code = 0, density_code = 0, diffusion_code = 0, gain_code = 0;
  logic [15:0] gain_hf_code = 0, early_delay_code = 0, late_delay_code = 0;
  logic [16:0] wet_gain = 0;
  logic last_zone = 0;
  logic signed [6:0] winner_index, neighbour_index;
  logic [15:0] blend_factor, out_decay, out_density, out_diffusion, out_gain;
  logic [15:0] out_gain_hf, out_early_delay, out_late_delay;
  logic [16:0] winner_weight, target_wet;

  reverb_zone_top_two_blend_unit dut (.*);

  always #10 clk = ~clk;

  // predictor state
  int unsigned zcount, bw, sw;
  int bslot, sslot;
  logic [15:0] bpar [NPARAM], spar [NPARAM];
  logic [16:0] bwet, swet;
  blend_t blend_q [$];
  int errors = 0, zones_sent = 0, sets_done = 0;
  bit hold_long = 0, stim_done = 0;

  function automatic int unsigned clamp_pos(logic signed [23:0] v);
    return v[23] ? 0 : int'(v[22:0]);
  endfunction

  function automatic longint unsigned mix16(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    return (a * (65536 - t) + b * t) >> 16;
  endfunction

  // Advance the local model by one zone; push the expected blend on the last zone.
  task automatic predict_zone(zone_t z);
    int unsigned r, b, d, w, t;
    logic [16:0] wet;
    blend_t e;
    longint unsigned bl;
    r = clamp_pos(z.r); b = clamp_pos(z.b); d = clamp_pos(z.d);
    wet = (z.wet > ONE_Q16) ? ONE_Q16 : z.wet;
    if (zcount < MAX_ZONES) begin
      if (d <= r) w = 65536;
      else if (b == 0 || d >= r + b) w = 0;
      else w = int'((longint'(r + b - d) << 16) / b);
      if (w > 0) begin
        if (w > bw) begin
          sw = bw; sslot = bslot; spar = bpar; swet = bwet;
          bw = w; bslot = zcount; bpar = z.p; bwet = wet;
        end else if (w > sw) begin
          sw = w; sslot = zcount; spar = z.p; swet = wet;
        end
      end
      zcount++;
    end
    if (!z.last) return;
    if (bslot < 0) begin
      e.wi = NO_SLOT; e.ni = NO_SLOT; e.t = 0; e.ww = 0; e.tw = 0;
      foreach (e.p[i]) e.p[i] = 0;
    end else begin
      t = 0;
      if (sslot >= 0) t = int'((longint'(sw) << 16) / (longint'(bw) + sw));
      e.wi = bslot[6:0]; e.ni = sslot[6:0]; e.t = t[15:0]; e.ww = bw[16:0];
      foreach (e.p[i]) e.p[i] = 16'(mix16(bpar[i], (sslot >= 0) ? spar[i] : bpar[i], t));
      bl = mix16(bwet, (sslot >= 0) ? swet : bwet, t);
      e.tw = 17'((bl * bw) >> 16);
    end
    blend_q.push_back(e);
    zcount = 0; bw = 0; sw = 0; bslot = -1; sslot = -1;
  endtask

  function automatic zone_t rand_zone(bit last);
    zone_t z;
    int m;
    m = $urandom_range(0, 9);
    z.r = (m == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
    z.b = (m == 1) ? 24'($urandom) : (m == 2) ? 0 : 24'($urandom_range(0, 4000));
    z.d = (m == 3) ? 24'($urandom) : 24'(clamp_pos(z.r) + $urandom_range(0, 5000));
    if (m == 4) z.d = z.r;
    foreach (z.p[i]) z.p[i] = 16'($urandom);
    z.wet = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    z.last = last;
    return z;
  endfunction

  function automatic zone_t mk(int r, int b, int d, int pv, int wet, bit last);
    zone_t z;
    z.r = 24'(r); z.b = 24'(b); z.d = 24'(d);
    foreach (z.p[i]) z.p[i] = 16'(pv);
    z.wet = 17'(wet); z.last = last;
    return z;
  endfunction

  // Drive one transaction and wait for acceptance.
  task automatic send_zone(zone_t z);
    @(negedge clk);
    in_valid <= 1;
    core_radius <= z.r; falloff_band <= z.b; distance <= z.d;
    decay_code <= z.p[0]; density_code <= z.p[1]; diffusion_code <= z.p[2];
    gain_code <= z.p[3]; gain_hf_code <= z.p[4]; early_delay_code <= z.p[5];
    late_delay_code <= z.p[6]; wet_gain <= z.wet; last_zone <= z.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_zone(z);
    zones_sent++;
  endtask

  task automatic chk(string f, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected %0h, actual %0h", f, exp, act);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      blend_t e;
      if (blend_q.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        e = blend_q.pop_front();
        chk("winner_index", e.wi, $unsigned(winner_index));
        chk("neighbour_index", e.ni, $unsigned(neighbour_index));
        chk("blend_factor", e.t, blend_factor);
        chk("winner_weight", e.ww, winner_weight);
        chk("out_decay", e.p[0], out_decay);
        chk("out_density", e.p[1], out_density);
        chk("out_diffusion", e.p[2], out_diffusion);
        chk("out_gain", e.p[3], out_gain);
        chk("out_gain_hf", e.p[4], out_gain_hf);
        chk("out_early_delay", e.p[5], out_early_delay);
        chk("out_late_delay", e.p[6], out_late_delay);
        chk("target_wet", e.tw, target_wet);
        sets_done++;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off.
  initial begin
    int k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 0;
        for (k = 0; k < 3000; k++) @(negedge clk);
        hold_long = 0;
      end
      k = $urandom_range(0, 15);
      out_ready <= (k < 10) || stim_done;
    end
  end

  // Watchdog on cycles without any transaction.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    zone_t tbl [$];
    int n, gap, burst, k, setlen;
    zcount = 0; bw = 0; sw = 0; bslot = -1; sslot = -1;
    foreach (bpar[i]) begin bpar[i] = 0; spar[i] = 0; end
    bwet = 0; swet = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;

    // Directed: no winner, full weight, falloff, ties, extremes, saturation.
    tbl.push_back(mk(0, 0, 100, 1, 1, 1));
    tbl.push_back(mk(-8388608, -8388608, -8388608, 16'hFFFF, 17'h1FFFF, 1));
    tbl.push_back(mk(8388607, 8388607, 8388607, 16'hFFFF, 65536, 1));
    tbl.push_back(mk(100, 200, 200, 100, 65536, 0));
    tbl.push_back(mk(100, 200, 200, 200, 30000, 1));
    tbl.push_back(mk(0, 8388607, 8388607, 16'hAAAA, 65535, 0));
    tbl.push_back(mk(0, 8388607, 1, 16'h5555, 17'h10001, 1));
    tbl.push_back(mk(10, 0, 11, 7, 9, 0));
    tbl.push_back(mk(10, 5, 15, 7, 9, 0));
    tbl.push_back(mk(10, 5, 12, 3, 9, 0));
    tbl.push_back(mk(50, 5, 50, 1000, 40000, 1));
    tbl.push_back(mk(8388607, 0, 0, 0, 0, 1));
    foreach (tbl[i]) send_zone(tbl[i]);
    @(negedge clk) in_valid <= 0;
    // a zone set longer than the tracked limit
    for (k = 0; k < MAX_ZONES + 6; k++) send_zone(rand_zone(k == MAX_ZONES + 5));

    // Random sets in bursts; long receiver hold mid-run.
    n = 0;
    while (n < 1500) begin
      setlen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
      if (n > 600 && n < 620) hold_long = 1;
      burst = $urandom_range(1, 8);
      for (k = 0; k < setlen; k++) begin
        send_zone(rand_zone(k == setlen - 1));
        n++;
        if (--burst == 0) begin
          @(negedge clk) in_valid <= 0;
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          repeat (gap) @(negedge clk);
          burst = $urandom_range(1, 8);
        end
      end
    end
    @(negedge clk) in_valid <= 0;
    stim_done = 1;

    while (blend_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d zones, checked %0d blend results.", zones_sent, sets_done);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
